[sv/awu_pkg.sv]
package awu_pkg;

    // Field widths of the item words.
    localparam int ADDR_W = 12;
    localparam int WORD_W = 32;
    localparam int CFG_W  = 24;

    // Register reset values.
    localparam logic [23:0] LR_RESET  = 24'd16777;
    localparam logic [23:0] EPS_RESET = 24'd1;
    localparam logic [15:0] B1_RESET  = 16'd58982;
    localparam logic [15:0] B2_RESET  = 16'd65470;

    // Largest step magnitude, 2^40.
    localparam logic [40:0] DELTA_CAP = 41'h100_0000_0000;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_LEARNING_RATE = 2'd0,
        CFG_EPSILON       = 2'd1,
        CFG_BETA_FIRST    = 2'd2,
        CFG_BETA_SECOND   = 2'd3
    } t_cfg_index;

    // Input word.
    typedef struct packed {
        logic [11:0]        element_address;
        logic signed [31:0] gradient;
        logic signed [31:0] weight;
        logic               last;
    } t_in_item;

    // Output word.
    typedef struct packed {
        logic signed [31:0] new_weight;
        logic               saturated;
        logic               last_out;
    } t_out_item;

endpackage

[sv/awu_moment.sv]
module awu_moment #(
    parameter int DEPTH = 4096,
    parameter int SW    = 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [awu_pkg::ADDR_W-1:0]  i_addr,
    input  logic signed [31:0]          i_gradient,
    input  logic [15:0]                 i_beta_first,
    input  logic [15:0]                 i_beta_second,
    input  logic [SW-1:0]               i_side,
    output logic                        o_busy,
    output logic                        o_valid,
    output logic signed [31:0]          o_first,
    output logic [47:0]                 o_second,
    output logic [SW-1:0]               o_side
);

    localparam int AW = $clog2(DEPTH);
    localparam logic [28:0] DEPTH_W = 29'(DEPTH);

    // Reduce the address modulo the depth, one conditional subtract a step.
    function automatic logic [AW-1:0] f_wrap(input logic [awu_pkg::ADDR_W-1:0] a);
        logic [28:0] rem;
        rem = 29'(a);
        for (int k = 7; k >= 0; k--) begin
            if (rem >= (DEPTH_W << k)) begin
                rem = rem - (DEPTH_W << k);
            end
        end
        return AW'(rem);
    endfunction

    logic signed [31:0] r_mem_first  [DEPTH];
    logic [47:0]        r_mem_second [DEPTH];

    logic               r_busy;
    logic [AW-1:0]      r_clr_cnt;

    logic               r_s1_valid;
    logic [AW-1:0]      r_s1_addr;
    logic signed [31:0] r_s1_rd_first;
    logic [47:0]        r_s1_rd_second;
    logic signed [31:0] r_s1_gradient;
    logic [46:0]        r_s1_gq;
    logic [SW-1:0]      r_s1_side;

    logic               r_fwd_valid;
    logic [AW-1:0]      r_fwd_addr;
    logic signed [31:0] r_fwd_first;
    logic [47:0]        r_fwd_second;

    logic               r_s2_valid;
    logic signed [31:0] r_s2_first;
    logic [47:0]        r_s2_second;
    logic [SW-1:0]      r_s2_side;

    logic [AW-1:0]      rd_addr;
    logic [31:0]        gmag;
    logic [63:0]        gsq;
    logic               fwd_hit;
    logic signed [31:0] old_first;
    logic [47:0]        old_second;
    logic [16:0]        nb1;
    logic [16:0]        nb2;
    logic signed [49:0] m_acc;
    logic [64:0]        v_acc;
    logic signed [31:0] new_first;
    logic [47:0]        new_second;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic signed [31:0] wr_first;
    logic [47:0]        wr_second;

    // Address reduction and gradient square ahead of the read stage.
    assign rd_addr = f_wrap(i_addr);
    assign gmag    = i_gradient[31] ? (~i_gradient + 32'd1) : i_gradient;
    assign gsq     = 64'(gmag) * 64'(gmag);

    // The previous item's write lands at the edge this item is read; take it from here.
    assign fwd_hit    = r_fwd_valid && (r_fwd_addr == r_s1_addr);
    assign old_first  = fwd_hit ? r_fwd_first  : r_s1_rd_first;
    assign old_second = fwd_hit ? r_fwd_second : r_s1_rd_second;

    // Moment updates.
    assign nb1        = 17'h1_0000 - {1'b0, i_beta_first};
    assign nb2        = 17'h1_0000 - {1'b0, i_beta_second};
    assign m_acc      = $signed({1'b0, i_beta_first}) * old_first
                      + $signed({1'b0, nb1}) * r_s1_gradient;
    assign v_acc      = 65'(i_beta_second) * 65'(old_second) + 65'(nb2) * 65'(r_s1_gq);
    assign new_first  = m_acc[47:16];
    assign new_second = v_acc[63:16];

    // Write port: clearing pass after reset, then write-back of updated moments.
    assign wr_en     = r_busy || (i_en && r_s1_valid);
    assign wr_addr   = r_busy ? r_clr_cnt : r_s1_addr;
    assign wr_first  = r_busy ? 32'sd0 : new_first;
    assign wr_second = r_busy ? 48'd0 : new_second;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem_first[wr_addr]  <= wr_first;
            r_mem_second[wr_addr] <= wr_second;
        end
        if (i_en) begin
            r_s1_rd_first  <= r_mem_first[rd_addr];
            r_s1_rd_second <= r_mem_second[rd_addr];
        end
    end

    // Clearing sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b1;
            r_clr_cnt <= '0;
        end else if (r_busy) begin
            r_clr_cnt <= r_clr_cnt + 1'b1;
            if (r_clr_cnt == AW'(DEPTH - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Control of both stages and the forwarding entry.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_fwd_valid <= 1'b0;
        end else if (i_en) begin
            r_s1_valid <= i_valid;
            r_s2_valid <= r_s1_valid;
            if (r_s1_valid) begin
                r_fwd_valid <= 1'b1;
            end
        end
    end

    // Stage payloads.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_addr     <= rd_addr;
            r_s1_gradient <= i_gradient;
            r_s1_gq       <= gsq[62:16];
            r_s1_side     <= i_side;
            r_s2_first    <= new_first;
            r_s2_second   <= new_second;
            r_s2_side     <= r_s1_side;
            if (r_s1_valid) begin
                r_fwd_addr   <= r_s1_addr;
                r_fwd_first  <= new_first;
                r_fwd_second <= new_second;
            end
        end
    end

    assign o_busy   = r_busy;
    assign o_valid  = r_s2_valid;
    assign o_first  = r_s2_first;
    assign o_second = r_s2_second;
    assign o_side   = r_s2_side;

endmodule

[sv/awu_sqrt.sv]
module awu_sqrt #(
    parameter int IW = 64,
    parameter int SW = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [IW-1:0]    i_rad,
    input  logic [SW-1:0]    i_side,
    output logic             o_valid,
    output logic [IW/2-1:0]  o_root,
    output logic [SW-1:0]    o_side
);

    localparam int RW = IW / 2;

    logic            r_vld  [RW];
    logic [RW+1:0]   r_rem  [RW];
    logic [RW-1:0]   r_root [RW];
    logic [IW-1:0]   r_rad  [RW];
    logic [SW-1:0]   r_side [RW];

    // One result bit per stage, two radicand bits consumed per stage.
    for (genvar j = 0; j < RW; j++) begin : g_stage
        logic            vld_in;
        logic [RW+1:0]   rem_in;
        logic [RW-1:0]   root_in;
        logic [IW-1:0]   rad_in;
        logic [SW-1:0]   side_in;
        logic [RW+3:0]   acc;
        logic [RW+3:0]   trial;
        logic [RW+3:0]   diff;

        if (j == 0) begin : g_head
            assign vld_in  = i_valid;
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = i_rad;
            assign side_in = i_side;
        end else begin : g_body
            assign vld_in  = r_vld[j-1];
            assign rem_in  = r_rem[j-1];
            assign root_in = r_root[j-1];
            assign rad_in  = r_rad[j-1];
            assign side_in = r_side[j-1];
        end

        assign acc   = {rem_in, rad_in[IW-1 -: 2]};
        assign trial = {2'b00, root_in, 2'b01};
        assign diff  = acc - trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else if (i_en) begin
                r_vld[j] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (acc >= trial) begin
                    r_rem[j]  <= diff[RW+1:0];
                    r_root[j] <= {root_in[RW-2:0], 1'b1};
                end else begin
                    r_rem[j]  <= acc[RW+1:0];
                    r_root[j] <= {root_in[RW-2:0], 1'b0};
                end
                r_rad[j]  <= {rad_in[IW-3:0], 2'b00};
                r_side[j] <= side_in;
            end
        end
    end

    assign o_valid = r_vld[RW-1];
    assign o_root  = r_root[RW-1];
    assign o_side  = r_side[RW-1];

endmodule

[sv/awu_div.sv]
module awu_div #(
    parameter int NW = 64,
    parameter int DW = 33,
    parameter int SW = 1
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  logic [NW-1:0]  i_num,
    input  logic [DW-1:0]  i_den,
    input  logic [SW-1:0]  i_side,
    output logic           o_valid,
    output logic [NW-1:0]  o_quo,
    output logic [SW-1:0]  o_side
);

    logic            r_vld  [NW];
    logic [DW-1:0]   r_rem  [NW];
    logic [NW-1:0]   r_nq   [NW];
    logic [DW-1:0]   r_den  [NW];
    logic [SW-1:0]   r_side [NW];

    // Restoring division, one quotient bit per stage. The dividend shifts out
    // of the top of r_nq while quotient bits shift in at the bottom.
    for (genvar j = 0; j < NW; j++) begin : g_stage
        logic            vld_in;
        logic [DW-1:0]   rem_in;
        logic [NW-1:0]   nq_in;
        logic [DW-1:0]   den_in;
        logic [SW-1:0]   side_in;
        logic [DW:0]     acc;
        logic [DW:0]     diff;
        logic            qbit;

        if (j == 0) begin : g_head
            assign vld_in  = i_valid;
            assign rem_in  = '0;
            assign nq_in   = i_num;
            assign den_in  = i_den;
            assign side_in = i_side;
        end else begin : g_body
            assign vld_in  = r_vld[j-1];
            assign rem_in  = r_rem[j-1];
            assign nq_in   = r_nq[j-1];
            assign den_in  = r_den[j-1];
            assign side_in = r_side[j-1];
        end

        assign acc  = {rem_in, nq_in[NW-1]};
        assign qbit = (acc >= {1'b0, den_in});
        assign diff = acc - {1'b0, den_in};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else if (i_en) begin
                r_vld[j] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j]  <= qbit ? diff[DW-1:0] : acc[DW-1:0];
                r_nq[j]   <= {nq_in[NW-2:0], qbit};
                r_den[j]  <= den_in;
                r_side[j] <= side_in;
            end
        end
    end

    assign o_valid = r_vld[NW-1];
    assign o_quo   = r_nq[NW-1];
    assign o_side  = r_side[NW-1];

endmodule

[sv/adam_weight_update.sv]
// Adam weight update, one parameter element per word.
// Input channel (i_in_valid / o_in_ready / i_in_item): address, gradient, weight
// and last-of-vector flag. Output channel (o_out_valid / i_out_ready / o_out_item):
// saturated new weight, saturation flag and a copy of the last flag, one word per
// input word, in order. Configuration (i_cfg_valid / o_cfg_ready, always ready)
// writes learning rate, epsilon and the two decay factors; writing a decay
// factor restarts its bias-correction power.
// Throughput is one word per cycle while the receiver is not stalling and the
// memories are not being cleared. From input accept to output valid a word passes
// two moment stages, 32 square-root stages, 64 divider stages, two multiply
// stages, 72 divider stages and the output register. Moments live in two memories
// read and rewritten in place; a back-to-back update of the same address is
// forwarded from the previous write. After reset all DEPTH entries of the moment
// memories are cleared, one entry a cycle; o_in_ready is low for that time while
// configuration is accepted. When the receiver stalls the whole pipeline holds and
// o_in_ready drops in the same cycle; words in flight are kept, none are dropped.
module adam_weight_update #(
    parameter int DEPTH = 4096
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  awu_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output awu_pkg::t_out_item  o_out_item,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [23:0]         i_cfg_data
);

    localparam int MSW = 97;

    logic [23:0]        r_learning_rate;
    logic [23:0]        r_epsilon;
    logic [15:0]        r_beta_first;
    logic [15:0]        r_beta_second;
    logic [31:0]        r_pow_first;
    logic [31:0]        r_pow_second;

    logic               r_m1_valid;
    logic [40:0]        r_m1_den;
    logic [47:0]        r_m1_hi;
    logic [47:0]        r_m1_lo;
    logic               r_m1_sign;
    logic signed [31:0] r_m1_w;
    logic               r_m1_last;

    logic               r_m2_valid;
    logic [71:0]        r_m2_prod;
    logic [40:0]        r_m2_den;
    logic               r_m2_den_zero;
    logic               r_m2_sign;
    logic signed [31:0] r_m2_w;
    logic               r_m2_last;

    logic               r_out_valid;
    awu_pkg::t_out_item r_out_item;

    logic               adv;
    logic               in_accept;
    logic               cfg_we;
    logic [47:0]        pow1_prod;
    logic [47:0]        pow2_prod;

    logic               mom_busy;
    logic               mom_valid;
    logic signed [31:0] mom_first;
    logic [47:0]        mom_second;
    logic [MSW-1:0]     mom_side;
    logic signed [31:0] mom_w;
    logic               mom_last;
    logic [32:0]        d1;
    logic [32:0]        d2;

    logic               sa_valid;
    logic [31:0]        s_root;
    logic [64:0]        sa_side;
    logic               sb_valid;
    logic [31:0]        r2_root;
    logic [32:0]        sb_d1;
    logic signed [31:0] sq_first;
    logic [31:0]        mmag;
    logic               sq_valid;

    logic               dd_valid;
    logic [63:0]        qd;
    logic [32:0]        dd_side;
    logic               dm_valid;
    logic [63:0]        qm;
    logic               dm_sign;

    logic               dp_valid;
    logic [71:0]        qp;
    logic [34:0]        dp_side;
    logic               fin_sign;
    logic signed [31:0] fin_w;
    logic               fin_last;
    logic               fin_den_zero;
    logic [40:0]        delta;
    logic signed [42:0] w_ext;
    logic signed [42:0] d_ext;
    logic signed [42:0] sum;
    logic               ovf;
    awu_pkg::t_out_item fin_item;

    // Pipeline advances unless a finished word is held by the receiver.
    assign adv         = !r_out_valid || i_out_ready;
    assign o_in_ready  = adv && !mom_busy;
    assign in_accept   = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid;

    // Configuration registers and bias-correction powers.
    assign pow1_prod = 48'(r_pow_first) * 48'(r_beta_first);
    assign pow2_prod = 48'(r_pow_second) * 48'(r_beta_second);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_learning_rate <= awu_pkg::LR_RESET;
            r_epsilon       <= awu_pkg::EPS_RESET;
            r_beta_first    <= awu_pkg::B1_RESET;
            r_beta_second   <= awu_pkg::B2_RESET;
            r_pow_first     <= {awu_pkg::B1_RESET, 16'd0};
            r_pow_second    <= {awu_pkg::B2_RESET, 16'd0};
        end else if (cfg_we) begin
            case (awu_pkg::t_cfg_index'(i_cfg_index))
                awu_pkg::CFG_LEARNING_RATE: begin
                    r_learning_rate <= i_cfg_data;
                end
                awu_pkg::CFG_EPSILON: begin
                    r_epsilon <= i_cfg_data;
                end
                awu_pkg::CFG_BETA_FIRST: begin
                    r_beta_first <= i_cfg_data[15:0];
                    r_pow_first  <= {i_cfg_data[15:0], 16'd0};
                end
                awu_pkg::CFG_BETA_SECOND: begin
                    r_beta_second <= i_cfg_data[15:0];
                    r_pow_second  <= {i_cfg_data[15:0], 16'd0};
                end
                default: begin
                end
            endcase
        end else if (in_accept && i_in_item.last) begin
            r_pow_first  <= pow1_prod[47:16];
            r_pow_second <= pow2_prod[47:16];
        end
    end

    // Moment memories with read-modify-write; the powers travel with the word.
    awu_moment #(
        .DEPTH (DEPTH),
        .SW    (MSW)
    ) u_moment (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (adv),
        .i_valid       (in_accept),
        .i_addr        (i_in_item.element_address),
        .i_gradient    (i_in_item.gradient),
        .i_beta_first  (r_beta_first),
        .i_beta_second (r_beta_second),
        .i_side        ({i_in_item.weight, i_in_item.last, r_pow_first, r_pow_second}),
        .o_busy        (mom_busy),
        .o_valid       (mom_valid),
        .o_first       (mom_first),
        .o_second      (mom_second),
        .o_side        (mom_side)
    );

    assign mom_w    = mom_side[96:65];
    assign mom_last = mom_side[64];
    assign d1       = 33'h1_0000_0000 - {1'b0, mom_side[63:32]};
    assign d2       = 33'h1_0000_0000 - {1'b0, mom_side[31:0]};

    // Root of the second moment and root of the second correction term.
    awu_sqrt #(
        .IW (64),
        .SW (65)
    ) u_sqrt_moment (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (mom_valid),
        .i_rad   ({mom_second, 16'd0}),
        .i_side  ({mom_first, mom_w, mom_last}),
        .o_valid (sa_valid),
        .o_root  (s_root),
        .o_side  (sa_side)
    );

    awu_sqrt #(
        .IW (64),
        .SW (33)
    ) u_sqrt_corr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (mom_valid),
        .i_rad   ({31'd0, d2}),
        .i_side  (d1),
        .o_valid (sb_valid),
        .o_root  (r2_root),
        .o_side  (sb_d1)
    );

    assign sq_first = sa_side[64:33];
    assign mmag     = sq_first[31] ? (~sq_first + 32'd1) : sq_first;
    assign sq_valid = sa_valid && sb_valid;

    // Denominator quotient and corrected first-moment magnitude.
    awu_div #(
        .NW (64),
        .DW (33),
        .SW (33)
    ) u_div_den (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (sq_valid),
        .i_num   ({16'd0, s_root, 16'd0}),
        .i_den   ({16'd0, r2_root[16:0]}),
        .i_side  (sa_side[32:0]),
        .o_valid (dd_valid),
        .o_quo   (qd),
        .o_side  (dd_side)
    );

    awu_div #(
        .NW (64),
        .DW (33),
        .SW (1)
    ) u_div_mom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (sq_valid),
        .i_num   ({mmag, 32'd0}),
        .i_den   (sb_d1),
        .i_side  (sq_first[31]),
        .o_valid (dm_valid),
        .o_quo   (qm),
        .o_side  (dm_sign)
    );

    // Denominator plus epsilon; step numerator as two partial products, then summed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_valid <= 1'b0;
            r_m2_valid <= 1'b0;
        end else if (adv) begin
            r_m1_valid <= dd_valid && dm_valid;
            r_m2_valid <= r_m1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_m1_den      <= qd[40:0] + 41'(r_epsilon);
            r_m1_hi       <= 48'(qm[47:24]) * 48'(r_learning_rate);
            r_m1_lo       <= 48'(qm[23:0]) * 48'(r_learning_rate);
            r_m1_sign     <= dm_sign;
            r_m1_w        <= dd_side[32:1];
            r_m1_last     <= dd_side[0];
            r_m2_prod     <= {r_m1_hi, 24'd0} + 72'(r_m1_lo);
            r_m2_den      <= r_m1_den;
            r_m2_den_zero <= (r_m1_den == 41'd0);
            r_m2_sign     <= r_m1_sign;
            r_m2_w        <= r_m1_w;
            r_m2_last     <= r_m1_last;
        end
    end

    // Step magnitude.
    awu_div #(
        .NW (72),
        .DW (41),
        .SW (35)
    ) u_div_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (r_m2_valid),
        .i_num   (r_m2_prod),
        .i_den   (r_m2_den),
        .i_side  ({r_m2_sign, r_m2_w, r_m2_last, r_m2_den_zero}),
        .o_valid (dp_valid),
        .o_quo   (qp),
        .o_side  (dp_side)
    );

    // Cap the step, apply it against the sign of the moment, saturate; a zero denominator leaves the weight unchanged.
    assign fin_sign     = dp_side[34];
    assign fin_w        = dp_side[33:2];
    assign fin_last     = dp_side[1];
    assign fin_den_zero = dp_side[0];
    assign delta        = (qp[71:40] != 32'd0) ? awu_pkg::DELTA_CAP : qp[40:0];
    assign w_ext        = {{11{fin_w[31]}}, fin_w};
    assign d_ext        = $signed({2'b00, delta});
    assign sum          = fin_sign ? (w_ext + d_ext) : (w_ext - d_ext);
    assign ovf          = !((&sum[42:31]) || (~|sum[42:31]));

    always_comb begin
        fin_item.last_out = fin_last;
        if (fin_den_zero) begin
            fin_item.new_weight = fin_w;
            fin_item.saturated  = 1'b0;
        end else if (ovf) begin
            fin_item.new_weight = sum[42] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            fin_item.saturated  = 1'b1;
        end else begin
            fin_item.new_weight = sum[31:0];
            fin_item.saturated  = 1'b0;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= dp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_item <= fin_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // The two roots must leave their pipelines together.
    a_sqrt_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sa_valid == sb_valid)
        else $error("square-root pipelines out of step");

    // The two dividers fed by the roots must stay together.
    a_div_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dd_valid == dm_valid)
        else $error("divider pipelines out of step");

    // A saturated word sits on one of the two rails.
    a_sat_rails: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_item.saturated) |->
        (r_out_item.new_weight == 32'sh7FFF_FFFF || r_out_item.new_weight == 32'sh8000_0000))
        else $error("saturated weight not at a rail");

    // The powers move only on an accepted last word or a configuration write.
    a_pow_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!cfg_we && !(in_accept && i_in_item.last)) |=>
        ($stable(r_pow_first) && $stable(r_pow_second)))
        else $error("bias-correction power changed without cause");

endmodule
